// ----- rtl/core/urst_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the unicast receiver session table.
package urst_pkg;

    localparam int MAX_FOLLOWERS_DEF = 4;
    localparam int RESULT_CAP        = 8;

    typedef enum logic [1:0] {
        OP_JOIN   = 2'd0,
        OP_LISTEN = 2'd1,
        OP_LEAVE  = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_TRACK    = 3'd0,
        K_METATEXT = 3'd1,
        K_HEADER   = 3'd2,
        K_ENTRY    = 3'd3,
        K_LISTEN   = 3'd4,
        K_LEAVE    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_OWN_ADDRESS = 2'd0,
        CFG_OWN_PORT    = 2'd1,
        CFG_EXPIRY      = 2'd2
    } t_cfg_idx;

    // Ordered: the emission states follow the order in which messages go out
    typedef enum logic [3:0] {
        S_IDLE   = 4'd0,
        S_EXEC   = 4'd1,
        S_PURGE  = 4'd2,
        S_LEAVE  = 4'd3,
        S_LISTEN = 4'd4,
        S_HDR    = 4'd5,
        S_ENT    = 4'd6,
        S_TRACK  = 4'd7,
        S_META   = 4'd8
    } t_state;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] deadline;
    } t_entry;

    typedef struct packed {
        logic take_next;
        logic load_all;
        logic load_deadline;
    } t_cell_ctl;

    typedef struct packed {
        logic leave;
        logic promote;
        logic listen;
        logic list;
        logic tm;
    } t_flags;

    // Wrap-safe: due when deadline - now is zero or negative
    function automatic logic f_due(input logic [31:0] deadline, input logic [31:0] now);
        logic [31:0] d;
        begin
            d = deadline - now;
            return (d == 32'd0) || d[31];
        end
    endfunction

endpackage

// ----- rtl/core/urst_cell.sv -----
`timescale 1ns / 1ps
// One follower slot of the table chain: holds an endpoint and its deadline.
module urst_cell
    import urst_pkg::*;
(
    input  logic        i_clk,
    input  t_cell_ctl   i_ctl,
    input  t_entry      i_next,
    input  t_entry      i_load,
    input  logic [31:0] i_key_address,
    input  logic [15:0] i_key_port,
    input  logic [31:0] i_now,
    output t_entry      o_entry,
    output logic        o_match,
    output logic        o_due
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.take_next) begin
            r_entry <= i_next;
        end else if (i_ctl.load_all) begin
            r_entry <= i_load;
        end else if (i_ctl.load_deadline) begin
            r_entry.deadline <= i_load.deadline;
        end
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry.address == i_key_address) && (r_entry.port == i_key_port);
    assign o_due   = f_due(r_entry.deadline, i_now);

endmodule

// ----- rtl/core/unicast_receiver_session_table_unit.sv -----
`timescale 1ns / 1ps
// Session table top level: sequencer, master registers and the follower cell chain.
// One input transaction at a time: it is taken in idle, decoded in the exec state, then
// each result passes through a one-deep output register, where it waits while the
// consumer stalls. A slave list walks the whole follower chain once, however many
// entries it holds; compaction after a listen from the master removes due followers
// one at a time in the purge state. Results are capped at eight per transaction.
module unicast_receiver_session_table_unit
    import urst_pkg::*;
#(
    parameter int MAX_FOLLOWERS = MAX_FOLLOWERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_sender_address,
    input  logic [15:0] i_sender_port,
    input  logic [31:0] i_now,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_message_kind,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_dest_port,
    output logic [2:0]  o_entry_count,
    output logic [31:0] o_entry_address,
    output logic [15:0] o_entry_port,
    output logic        o_session_active,
    output logic        o_last
);

    localparam int CW  = $clog2(MAX_FOLLOWERS + 1);
    localparam int IW  = (MAX_FOLLOWERS > 1) ? $clog2(MAX_FOLLOWERS) : 1;
    localparam int NRW = $clog2(RESULT_CAP + 1);

    // configuration
    logic [31:0] r_own_address;
    logic [15:0] r_own_port;
    logic [15:0] r_expiry;

    // sequencer and session state
    t_state      r_state, n_state;
    t_flags      r_flags, n_flags;
    logic        r_in_session, n_in_session;
    logic [31:0] r_maddr, n_maddr;
    logic [15:0] r_mport, n_mport;
    logic [31:0] r_mdl, n_mdl;
    logic        r_armed, n_armed;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_k, n_k;
    logic [NRW-1:0] r_nres, n_nres;

    // latched transaction
    t_op         r_op;
    logic [31:0] r_ka;
    logic [15:0] r_kp;
    logic [31:0] r_now;

    // output register
    logic        r_ov, n_ov;
    t_kind       r_o_kind;
    logic [31:0] r_o_daddr;
    logic [15:0] r_o_dport;
    logic [2:0]  r_o_cnt;
    logic [31:0] r_o_eaddr;
    logic [15:0] r_o_eport;
    logic        r_o_sess;
    logic        r_o_last;

    // chain
    t_entry      w_ent   [MAX_FOLLOWERS];
    t_cell_ctl   w_ctl   [MAX_FOLLOWERS];
    logic [MAX_FOLLOWERS-1:0] w_match, w_due, w_live;
    t_entry      w_load;
    t_entry      w_prom;

    logic          fvalid, dvalid;
    logic [IW-1:0] fidx, didx;
    logic          rot_en, rem_en, add_en, ref_en;
    logic [IW-1:0] rem_idx, ref_idx;
    logic [IW-1:0] add_idx, prom_idx;
    logic [CW-1:0] cnt_m1;
    logic [CW+2:0] cnt_ext;

    logic        emit, e_last;
    t_kind       e_kind;
    logic [2:0]  e_cnt;
    logic [31:0] e_ea;
    logic [15:0] e_ep;
    logic        emit_ok, out_free, step;
    logic        is_master, is_self, do_leave, purge, ent_emit, ent_adv;
    logic [31:0] dl_new;
    t_flags      nf;

    function automatic t_state next_after(input t_flags f, input t_state s);
        t_state nx;
        begin
            nx = S_IDLE;
            if (f.tm && s < S_TRACK) nx = S_TRACK;
            if (f.list && s < S_HDR) nx = S_HDR;
            if (f.listen && s < S_LISTEN) nx = S_LISTEN;
            if (f.leave && s < S_LEAVE) nx = S_LEAVE;
            return nx;
        end
    endfunction

    assign dl_new    = r_now + {16'd0, r_expiry};
    assign w_load    = '{address: r_ka, port: r_kp, deadline: dl_new};
    assign cnt_m1    = r_count - CW'(1);
    assign prom_idx  = cnt_m1[IW-1:0];
    assign add_idx   = r_count[IW-1:0];
    assign w_prom    = w_ent[prom_idx];
    assign is_master = (r_ka == r_maddr) && (r_kp == r_mport);
    assign is_self   = (r_ka == r_own_address) && (r_kp == r_own_port);
    assign cnt_ext   = {3'd0, r_count};

    genvar j;
    generate
        for (j = 0; j < MAX_FOLLOWERS; j++) begin : g_cell
            localparam logic [IW-1:0] JI = IW'(j);
            localparam logic [CW-1:0] JC = CW'(j);
            localparam int NX = (j + 1) % MAX_FOLLOWERS;

            assign w_live[j] = JC < r_count;
            assign w_ctl[j].take_next = rot_en || (rem_en && JI >= rem_idx);
            assign w_ctl[j].load_all = add_en && (add_idx == JI);
            assign w_ctl[j].load_deadline = ref_en && (ref_idx == JI);

            urst_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl[j]),
                .i_next       (w_ent[NX]),
                .i_load       (w_load),
                .i_key_address(r_ka),
                .i_key_port   (r_kp),
                .i_now        (r_now),
                .o_entry      (w_ent[j]),
                .o_match      (w_match[j]),
                .o_due        (w_due[j])
            );
        end
    endgenerate

    // lowest live slot that matches the key / is due
    always_comb begin
        fvalid = 1'b0;
        fidx   = '0;
        dvalid = 1'b0;
        didx   = '0;
        for (int i = MAX_FOLLOWERS - 1; i >= 0; i--) begin
            if (w_match[i] && w_live[i]) begin
                fvalid = 1'b1;
                fidx   = IW'(i);
            end
            if (w_due[i] && w_live[i]) begin
                dvalid = 1'b1;
                didx   = IW'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_flags      = r_flags;
        n_in_session = r_in_session;
        n_maddr      = r_maddr;
        n_mport      = r_mport;
        n_mdl        = r_mdl;
        n_armed      = r_armed;
        n_count      = r_count;
        n_k          = r_k;
        n_nres       = r_nres;
        rot_en   = 1'b0;
        rem_en   = 1'b0;
        rem_idx  = '0;
        add_en   = 1'b0;
        ref_en   = 1'b0;
        ref_idx  = '0;
        emit     = 1'b0;
        e_last   = 1'b0;
        e_kind   = K_TRACK;
        e_cnt    = 3'd0;
        e_ea     = 32'd0;
        e_ep     = 16'd0;
        do_leave = 1'b0;
        purge    = 1'b0;
        ent_emit = 1'b0;
        ent_adv  = 1'b0;
        nf       = '0;
        emit_ok  = r_nres < NRW'(RESULT_CAP);
        out_free = !r_ov || i_out_ready;
        step     = !emit_ok || out_free;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_nres = '0;
                if (!r_in_session) begin
                    if (r_op == OP_JOIN || r_op == OP_LISTEN) begin
                        n_maddr      = r_ka;
                        n_mport      = r_kp;
                        n_count      = '0;
                        n_in_session = 1'b1;
                        n_mdl        = dl_new;
                        n_armed      = 1'b1;
                        nf.tm        = 1'b1;
                    end
                end else begin
                    unique case (r_op)
                        OP_JOIN: begin
                            if (is_master) begin
                                n_mdl   = dl_new;
                                n_armed = 1'b1;
                            end else if (fvalid) begin
                                ref_en  = 1'b1;
                                ref_idx = fidx;
                            end else if (r_count < CW'(MAX_FOLLOWERS)) begin
                                add_en    = 1'b1;
                                n_count   = r_count + CW'(1);
                                nf.listen = 1'b1;
                            end
                            nf.list = 1'b1;
                            nf.tm   = 1'b1;
                        end
                        OP_LISTEN: begin
                            if (is_master) begin
                                n_mdl   = dl_new;
                                n_armed = 1'b1;
                                purge   = 1'b1;
                            end else if (fvalid) begin
                                ref_en  = 1'b1;
                                ref_idx = fidx;
                            end else if (r_count < CW'(MAX_FOLLOWERS)) begin
                                add_en    = 1'b1;
                                n_count   = r_count + CW'(1);
                                nf.listen = 1'b1;
                                nf.list   = 1'b1;
                                nf.tm     = 1'b1;
                            end
                        end
                        OP_LEAVE: do_leave = 1'b1;
                        OP_TICK: begin
                            if (r_armed && f_due(r_mdl, r_now)) begin
                                n_armed  = 1'b0;
                                do_leave = 1'b1;
                            end
                        end
                    endcase
                    if (do_leave) begin
                        if (is_master || is_self) begin
                            if (r_count == '0) begin
                                nf.leave     = is_master;
                                n_in_session = 1'b0;
                                n_armed      = 1'b0;
                            end else begin
                                nf.leave   = 1'b1;
                                nf.promote = 1'b1;
                                nf.list    = r_count > CW'(1);
                            end
                        end else if (fvalid) begin
                            rem_en   = 1'b1;
                            rem_idx  = fidx;
                            n_count  = cnt_m1;
                            nf.leave = 1'b1;
                            nf.list  = 1'b1;
                        end
                    end
                end
                n_flags = nf;
                n_state = purge ? S_PURGE : next_after(nf, S_EXEC);
            end
            S_PURGE: begin
                if (dvalid) begin
                    rem_en       = 1'b1;
                    rem_idx      = didx;
                    n_count      = cnt_m1;
                    n_flags.list = 1'b1;
                end else begin
                    n_state = next_after(r_flags, S_PURGE);
                end
            end
            S_LEAVE: begin
                if (step) begin
                    emit   = emit_ok;
                    e_kind = K_LEAVE;
                    e_last = next_after(r_flags, S_LEAVE) == S_IDLE;
                    if (r_flags.promote) begin
                        // old master goes out with the leave, last follower takes over
                        n_maddr = w_prom.address;
                        n_mport = w_prom.port;
                        n_mdl   = w_prom.deadline;
                        n_armed = 1'b1;
                        n_count = cnt_m1;
                    end
                    n_state = next_after(r_flags, S_LEAVE);
                end
            end
            S_LISTEN: begin
                if (step) begin
                    emit    = emit_ok;
                    e_kind  = K_LISTEN;
                    e_last  = next_after(r_flags, S_LISTEN) == S_IDLE;
                    n_state = next_after(r_flags, S_LISTEN);
                end
            end
            S_HDR: begin
                if (step) begin
                    emit    = emit_ok;
                    e_kind  = K_HEADER;
                    e_cnt   = cnt_ext[2:0];
                    e_last  = (r_count == '0) && !r_flags.tm;
                    n_k     = '0;
                    n_state = (r_count != '0) ? S_ENT : next_after(r_flags, S_ENT);
                end
            end
            S_ENT: begin
                // rotate the whole ring once; live slots pass cell 0 in order
                ent_emit = r_k < r_count;
                ent_adv  = !(ent_emit && emit_ok) || out_free;
                if (ent_adv) begin
                    rot_en = 1'b1;
                    emit   = ent_emit && emit_ok;
                    e_kind = K_ENTRY;
                    e_ea   = w_ent[0].address;
                    e_ep   = w_ent[0].port;
                    e_last = (r_k == cnt_m1) && !r_flags.tm;
                    n_k    = r_k + CW'(1);
                    if (r_k == CW'(MAX_FOLLOWERS - 1)) n_state = next_after(r_flags, S_ENT);
                end
            end
            S_TRACK: begin
                if (step) begin
                    emit    = emit_ok;
                    e_kind  = K_TRACK;
                    n_state = S_META;
                end
            end
            S_META: begin
                if (step) begin
                    emit    = emit_ok;
                    e_kind  = K_METATEXT;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // the eighth result closes the transaction, later ones are dropped
        if (r_nres == NRW'(RESULT_CAP - 1)) e_last = 1'b1;
        if (emit) n_nres = r_nres + NRW'(1);

        if (emit) n_ov = 1'b1;
        else if (i_out_ready) n_ov = 1'b0;
        else n_ov = r_ov;
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_flags       <= '0;
            r_in_session  <= 1'b0;
            r_maddr       <= 32'd0;
            r_mport       <= 16'd0;
            r_mdl         <= 32'd0;
            r_armed       <= 1'b0;
            r_count       <= '0;
            r_k           <= '0;
            r_nres        <= '0;
            r_ov          <= 1'b0;
            r_own_address <= 32'd0;
            r_own_port    <= 16'd0;
            r_expiry      <= 16'd10000;
        end else begin
            r_state      <= n_state;
            r_flags      <= n_flags;
            r_in_session <= n_in_session;
            r_maddr      <= n_maddr;
            r_mport      <= n_mport;
            r_mdl        <= n_mdl;
            r_armed      <= n_armed;
            r_count      <= n_count;
            r_k          <= n_k;
            r_nres       <= n_nres;
            r_ov         <= n_ov;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OWN_ADDRESS: r_own_address <= i_cfg_data;
                    CFG_OWN_PORT:    r_own_port    <= i_cfg_data[15:0];
                    CFG_EXPIRY:      r_expiry      <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op  <= t_op'(i_operation);
            // a tick that fires acts as a leave from the own address and port
            r_ka  <= (t_op'(i_operation) == OP_TICK) ? r_own_address : i_sender_address;
            r_kp  <= (t_op'(i_operation) == OP_TICK) ? r_own_port : i_sender_port;
            r_now <= i_now;
        end
        if (emit) begin
            r_o_kind  <= e_kind;
            r_o_daddr <= r_maddr;
            r_o_dport <= r_mport;
            r_o_cnt   <= e_cnt;
            r_o_eaddr <= e_ea;
            r_o_eport <= e_ep;
            r_o_sess  <= r_in_session;
            r_o_last  <= e_last;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_message_kind   = r_o_kind;
    assign o_dest_address   = r_o_daddr;
    assign o_dest_port      = r_o_dport;
    assign o_entry_count    = r_o_cnt;
    assign o_entry_address  = r_o_eaddr;
    assign o_entry_port     = r_o_eport;
    assign o_session_active = r_o_sess;
    assign o_last           = r_o_last;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FOLLOWERS))
        else $error("follower count beyond table size");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_session |-> (r_count == '0) && !r_armed)
        else $error("followers or timer left without a session");

    a_results_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NRW'(RESULT_CAP))
        else $error("result counter past cap");
`endif

endmodule
